// File: design/gps_time_of_week_from_date_unit_macros.svh
// assertion macros shared by the pipeline modules
`ifndef GPS_TIME_OF_WEEK_FROM_DATE_UNIT_MACROS_SVH
`define GPS_TIME_OF_WEEK_FROM_DATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GTOW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtow assertion failed");
// next-cycle implication
`define GTOW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtow assertion failed");
`else
`define GTOW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GTOW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/gtow_pkg.sv
`default_nettype none
package gtow_pkg;

    localparam logic [13:0] YearBase     = 14'd2000;
    localparam logic [13:0] YearWrap     = 14'd4000;
    localparam logic [21:0] MsPerHour    = 22'd3600000;
    localparam logic [15:0] MsPerMinute  = 16'd60000;
    // x / 25 == (x * RecipQ) >> RecipShift for every 12-bit x used here
    localparam logic [12:0] RecipQ       = 13'd5243;
    localparam int          RecipShift   = 17;
    localparam logic [6:0]  Century      = 7'd100;
    localparam logic [3:0]  MonthMax     = 4'd12;
    localparam logic [3:0]  MonthFeb     = 4'd2;
    // epoch offset 360 - 1981 - leaps(1980), taken modulo 7
    localparam logic [14:0] WeekOffset   = 15'd6;
    localparam logic [3:0]  DaysPerWeek  = 4'd7;

    typedef struct packed {
        logic [13:0] year;
        logic [11:0] lcnt;
        logic [8:0]  doy;
        logic [26:0] tod;
    } t_day_info;

    // days before the first of the month
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] r;
        unique case (month)
            4'd3:    r = 9'd59;
            4'd2:    r = 9'd31;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // weekday times one day in ms
    function automatic logic [29:0] weekday_ms(input logic [2:0] wd);
        logic [29:0] r;
        unique case (wd)
            3'd1:    r = 30'd86400000;
            3'd2:    r = 30'd172800000;
            3'd3:    r = 30'd259200000;
            3'd4:    r = 30'd345600000;
            3'd5:    r = 30'd432000000;
            3'd6:    r = 30'd518400000;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/gps_time_of_week_from_date_unit.sv
// five register stages, the last is the output register
// throughput: one transaction per cycle while the output accepts; a stall at the output
// holds each valid stage until the next one frees, nothing is dropped or repeated
// reset (synchronous, active low) clears all stage valid bits, the data registers keep their value
`default_nettype none
module gps_time_of_week_from_date_unit
    import gtow_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [13:0] i_year_in,
    input  wire logic [3:0]  i_month_in,
    input  wire logic [4:0]  i_day_in,
    input  wire logic [4:0]  i_hour_in,
    input  wire logic [5:0]  i_minute_in,
    input  wire logic [15:0] i_second_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [29:0]      o_week_seconds_ms,
    output logic [8:0]       o_day_of_year
);

    logic      w_mid_valid;
    logic      w_mid_ready;
    t_day_info w_mid_info;

    gtow_day_pipe u_day (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_year_in   (i_year_in),
        .i_month_in  (i_month_in),
        .i_day_in    (i_day_in),
        .i_hour_in   (i_hour_in),
        .i_minute_in (i_minute_in),
        .i_second_ms (i_second_ms),
        .o_valid     (w_mid_valid),
        .i_ready     (w_mid_ready),
        .o_info      (w_mid_info)
    );

    gtow_week_pipe u_week (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_mid_valid),
        .o_ready           (w_mid_ready),
        .i_info            (w_mid_info),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_week_seconds_ms (o_week_seconds_ms),
        .o_day_of_year     (o_day_of_year)
    );

endmodule
`default_nettype wire

// File: design/gtow_day_pipe.sv
`default_nettype none
`include "gps_time_of_week_from_date_unit_macros.svh"
module gtow_day_pipe
    import gtow_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [13:0] i_year_in,
    input  wire logic [3:0]  i_month_in,
    input  wire logic [4:0]  i_day_in,
    input  wire logic [4:0]  i_hour_in,
    input  wire logic [5:0]  i_minute_in,
    input  wire logic [15:0] i_second_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_day_info        o_info
);

    logic r_v1, r_v2, r_v3;
    logic w_adv1, w_adv2, w_adv3;

    // stage 1
    logic [13:0] n_year1, r_year1, r_ym1_1;
    logic [3:0]  n_month1, r_month1;
    logic [4:0]  r_day1, r_hour1;
    logic [5:0]  r_min1;
    logic [15:0] r_sec1;

    // stage 2
    logic [24:0] w_prod_y, w_prod_m;
    logic [13:0] r_year2, r_ym1_2;
    logic [7:0]  r_q100y2, r_q100m2;
    logic [8:0]  r_cum2;
    logic        r_gt2_2;
    logic [4:0]  r_day2;
    logic [26:0] r_toh2;
    logic [21:0] r_tom2;
    logic [15:0] r_sec2;

    // stage 3
    logic [13:0] w_cent;
    logic        w_leap;
    t_day_info   r_info3;

    assign w_adv3  = !r_v3 || i_ready;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v3;
    assign o_info  = r_info3;

    always_comb begin
        n_year1 = i_year_in;
        priority if (i_year_in < YearBase) begin
            n_year1 = i_year_in + YearBase;
        end else if (i_year_in > YearWrap) begin
            n_year1 = i_year_in - YearBase;
        end
        n_month1 = (i_month_in > MonthMax) ? MonthMax : i_month_in;
    end

    // divide by 100 as (y >> 2) / 25
    assign w_prod_y = 25'(r_year1[13:2]) * 25'(RecipQ);
    assign w_prod_m = 25'(r_ym1_1[13:2]) * 25'(RecipQ);

    assign w_cent = 14'(r_q100y2) * 14'(Century);
    assign w_leap = (r_year2[1:0] == 2'd0)
                 && ((w_cent != r_year2) || (r_q100y2[1:0] == 2'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_year1  <= n_year1;
            r_ym1_1  <= n_year1 - 14'd1;
            r_month1 <= n_month1;
            r_day1   <= i_day_in;
            r_hour1  <= i_hour_in;
            r_min1   <= i_minute_in;
            r_sec1   <= i_second_ms;
        end
        if (w_adv2 && r_v1) begin
            r_year2  <= r_year1;
            r_ym1_2  <= r_ym1_1;
            r_q100y2 <= w_prod_y[RecipShift +: 8];
            r_q100m2 <= w_prod_m[RecipShift +: 8];
            r_cum2   <= cum_days(r_month1);
            r_gt2_2  <= r_month1 > MonthFeb;
            r_day2   <= r_day1;
            r_toh2   <= 27'(r_hour1) * 27'(MsPerHour);
            r_tom2   <= 22'(r_min1) * 22'(MsPerMinute);
            r_sec2   <= r_sec1;
        end
        if (w_adv3 && r_v2) begin
            r_info3.year <= r_year2;
            // leap years in 1..year-1
            r_info3.lcnt <= r_ym1_2[13:2] - 12'(r_q100m2) + 12'(r_q100m2[7:2]);
            r_info3.doy  <= r_cum2 + 9'(r_day2) + 9'(w_leap && r_gt2_2);
            r_info3.tod  <= r_toh2 + 27'(r_tom2) + 27'(r_sec2);
        end
    end

    `GTOW_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_valid && o_ready, r_v1)
    `GTOW_ASSERT_NOW(a_year_norm, i_clk, i_rst_n, r_v2, r_year2 >= YearBase)
    `GTOW_ASSERT_NOW(a_doy_range, i_clk, i_rst_n, o_valid, o_info.doy <= 9'd366)

endmodule
`default_nettype wire

// File: design/gtow_week_pipe.sv
`default_nettype none
`include "gps_time_of_week_from_date_unit_macros.svh"
module gtow_week_pipe
    import gtow_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_day_info   i_info,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [29:0]      o_week_seconds_ms,
    output logic [8:0]       o_day_of_year
);

    logic r_v4, r_v5;
    logic w_adv4, w_adv5;

    logic [14:0] w_sum;
    logic [5:0]  w_f1, r_f1;
    logic [8:0]  r_doy4, r_doy5;
    logic [26:0] r_tod4;
    logic [3:0]  w_f2;
    logic [2:0]  w_wd;
    logic [29:0] r_tow5;

    assign w_adv5  = !r_v5 || i_ready;
    assign w_adv4  = !r_v4 || w_adv5;
    assign o_ready = w_adv4;
    assign o_valid = r_v5;
    assign o_week_seconds_ms = r_tow5;
    assign o_day_of_year     = r_doy5;

    // day count mod 7: 365 is 1 mod 7, and 8 is 1 mod 7 so 3-bit digits fold
    assign w_sum = 15'(i_info.year) + 15'(i_info.lcnt) + 15'(i_info.doy) + WeekOffset;
    assign w_f1  = 6'(w_sum[14:12]) + 6'(w_sum[11:9]) + 6'(w_sum[8:6])
                 + 6'(w_sum[5:3]) + 6'(w_sum[2:0]);
    assign w_f2  = 4'(r_f1[5:3]) + 4'(r_f1[2:0]);
    assign w_wd  = (w_f2 >= DaysPerWeek) ? 3'(w_f2 - DaysPerWeek) : w_f2[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_adv4) r_v4 <= i_valid;
            if (w_adv5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4 && i_valid) begin
            r_f1   <= w_f1;
            r_doy4 <= i_info.doy;
            r_tod4 <= i_info.tod;
        end
        if (w_adv5 && r_v4) begin
            r_tow5 <= 30'(r_tod4) + weekday_ms(w_wd);
            r_doy5 <= r_doy4;
        end
    end

    `GTOW_ASSERT_NOW(a_fold_range, i_clk, i_rst_n, r_v4, r_f1 <= 6'd35)
    `GTOW_ASSERT_NOW(a_tow_bound, i_clk, i_rst_n, o_valid, o_week_seconds_ms <= 30'd633845535)
    `GTOW_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, r_v5 && !i_ready && r_v4, r_v5 && r_v4)

endmodule
`default_nettype wire
